/* rtl/core/vmls_pkg.sv */
// ----------------------------------------------------------------------------
// vmls_pkg
// Shared sizes, register indexes and controller/datapath interface types
// for the vote max level selector.
// ----------------------------------------------------------------------------
package vmls_pkg;

  localparam int SLOTS       = 8;
  localparam int LEVEL_BITS  = 4;
  localparam int VOTE_BITS   = 8;

  localparam int SLOT_IDX_W  = 3;   // index into the slots
  localparam int SLOT_CNT_W  = 4;   // slots_in_use register width
  localparam int TABLE_W     = 32;  // slot_level_table register width
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TABLE  = 2'd1;

  localparam logic OP_VOTE   = 1'b0;
  localparam logic OP_UNVOTE = 1'b1;

  localparam logic [VOTE_BITS-1:0] VOTE_MAX = {VOTE_BITS{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } vmls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic none_used;
  } vmls_sts_t;

  function automatic logic [LEVEL_BITS-1:0] slot_level(
    input logic [TABLE_W-1:0]    tbl,
    input logic [SLOT_IDX_W-1:0] idx
  );
    slot_level = tbl[idx*LEVEL_BITS +: LEVEL_BITS];
  endfunction

endpackage

/* rtl/core/vmls_ctrl.sv */
// ----------------------------------------------------------------------------
// vmls_ctrl
// Sequencer: accepts a word, walks the slots one per cycle, then closes the
// item with the result update.
// ----------------------------------------------------------------------------
module vmls_ctrl
  import vmls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  vmls_sts_t sts,
  output vmls_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // no slot in use: nothing to walk
        if (sts.none_used) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* rtl/core/vmls_dp.sv */
// ----------------------------------------------------------------------------
// vmls_dp
// Datapath: config registers, vote counters, per-slot update and max scan,
// and the result masks.
// ----------------------------------------------------------------------------
module vmls_dp
  import vmls_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  vmls_cmd_t              cmd,
  output vmls_sts_t              sts,
  input  logic                   in_op,
  input  logic [LEVEL_BITS-1:0]  in_level,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                   out_valid,
  output logic                   out_changed,
  output logic [LEVEL_BITS-1:0]  out_active_level,
  output logic [SLOTS-1:0]       out_activate_mask,
  output logic [SLOTS-1:0]       out_deactivate_mask
);

  logic [SLOT_CNT_W-1:0] slots_in_use_r;
  logic [TABLE_W-1:0]    level_table_r;

  logic [VOTE_BITS-1:0]  counts_r [SLOTS];

  logic                  op_r;
  logic [LEVEL_BITS-1:0] lvl_r;
  logic [SLOT_IDX_W-1:0] idx_r;
  logic                  found_r;
  logic [LEVEL_BITS-1:0] best_r;

  logic                  cur_valid_r;
  logic [LEVEL_BITS-1:0] cur_level_r;

  logic                  out_valid_r;
  logic                  out_changed_r;
  logic [LEVEL_BITS-1:0] out_level_r;
  logic [SLOTS-1:0]      out_act_r;
  logic [SLOTS-1:0]      out_deact_r;

  logic [SLOT_CNT_W-1:0] used_n;
  logic [LEVEL_BITS-1:0] scan_lvl;
  logic [VOTE_BITS-1:0]  scan_cnt;
  logic                  scan_hit;
  logic [VOTE_BITS-1:0]  scan_cnt_nxt;
  logic                  changed;
  logic [SLOTS-1:0]      act_mask;
  logic [SLOTS-1:0]      deact_mask;

  // slots_in_use above the slot count counts as all slots
  assign used_n = (slots_in_use_r > SLOT_CNT_W'(SLOTS)) ? SLOT_CNT_W'(SLOTS) : slots_in_use_r;

  assign sts.none_used = (used_n == '0);
  assign sts.scan_last = ((SLOT_CNT_W'(idx_r) + SLOT_CNT_W'(1)) == used_n);

  assign scan_lvl = slot_level(level_table_r, idx_r);
  assign scan_cnt = counts_r[idx_r];
  assign scan_hit = !found_r && (scan_lvl == lvl_r);

  always_comb begin
    scan_cnt_nxt = scan_cnt;
    if (scan_hit) begin
      if (op_r == OP_VOTE) begin
        if (scan_cnt != VOTE_MAX) begin
          scan_cnt_nxt = scan_cnt + VOTE_BITS'(1);
        end
      end else if (scan_cnt != '0) begin
        scan_cnt_nxt = scan_cnt - VOTE_BITS'(1);
      end
    end
  end

  assign changed = !cur_valid_r || (cur_level_r != best_r);

  always_comb begin
    act_mask   = '0;
    deact_mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (changed && (SLOT_CNT_W'(i) < used_n)) begin
        if (slot_level(level_table_r, SLOT_IDX_W'(i)) == best_r) begin
          act_mask[i] = 1'b1;
        end else if (cur_valid_r &&
                     slot_level(level_table_r, SLOT_IDX_W'(i)) == cur_level_r) begin
          deact_mask[i] = 1'b1;
        end
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= '0;
      level_table_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SLOTS_IN_USE) begin
        slots_in_use_r <= cfg_wdata[SLOT_CNT_W-1:0];
      end else if (cfg_index == CFG_LEVEL_TABLE) begin
        level_table_r <= cfg_wdata[TABLE_W-1:0];
      end
    end
  end

  // counters and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        counts_r[i] <= '0;
      end
      cur_valid_r <= 1'b0;
      cur_level_r <= '0;
      found_r     <= 1'b0;
      best_r      <= '0;
      idx_r       <= '0;
    end else begin
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        best_r  <= '0;
      end
      if (cmd.step) begin
        counts_r[idx_r] <= scan_cnt_nxt;
        found_r         <= found_r | scan_hit;
        // max uses the count as updated in this very cycle
        if ((scan_cnt_nxt != '0) && (scan_lvl > best_r)) begin
          best_r <= scan_lvl;
        end
        idx_r <= idx_r + SLOT_IDX_W'(1);
      end
      if (cmd.finish && changed) begin
        cur_valid_r <= 1'b1;
        cur_level_r <= best_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      lvl_r <= in_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_changed_r <= changed;
      out_level_r   <= best_r;
      out_act_r     <= act_mask;
      out_deact_r   <= deact_mask;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_changed         = out_changed_r;
  assign out_active_level    = out_level_r;
  assign out_activate_mask   = out_act_r;
  assign out_deactivate_mask = out_deact_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_level_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cur_valid_r && cur_level_r == out_level_r))
    else $error("stored level does not match reported level");

  a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_act_r & out_deact_r) == '0))
    else $error("slot both activated and deactivated");

  a_masks_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_changed_r) |-> (out_act_r == '0 && out_deact_r == '0))
    else $error("masks set without a level change");

endmodule

/* rtl/core/vote_max_level_selector.sv */
// ----------------------------------------------------------------------------
// vote_max_level_selector
// Per-slot saturating vote counters with a tracked highest voted level and
// activate/deactivate slot masks on each level change.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  input    | start & !busy       | in_op, in_level
//  result   | out_valid (1 cycle) | out_changed, out_active_level,
//           |                     | out_activate_mask, out_deactivate_mask
//  config   | cfg_we              | cfg_index, cfg_wdata
//
//  an item passes through accept, a scan of each slot in use (n = slots in
//  use, at most 8) for the shared update/max scan (an idle scan state when no
//  slot is in use), then finish; a new item is taken only once busy is low
//  result strobe comes the cycle after finish; busy is low in that cycle
//  sync active-low reset clears counters, config and the stored level
//  the receiver cannot stall; every item yields exactly one result word
// ----------------------------------------------------------------------------
module vote_max_level_selector
  import vmls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [LEVEL_BITS-1:0] in_level,
  output logic                  out_valid,
  output logic                  out_changed,
  output logic [LEVEL_BITS-1:0] out_active_level,
  output logic [SLOTS-1:0]      out_activate_mask,
  output logic [SLOTS-1:0]      out_deactivate_mask,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  vmls_cmd_t cmd;
  vmls_sts_t sts;

  vmls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  vmls_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_level            (in_level),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_changed         (out_changed),
    .out_active_level    (out_active_level),
    .out_activate_mask   (out_activate_mask),
    .out_deactivate_mask (out_deactivate_mask)
  );

endmodule
